// ----- sv/dlf_pkg.sv -----
// Package for the delimiter line framer: shared types, register indexes,
// operation and status codes, and reset values.
// No dependencies.
`default_nettype none

package dlf_pkg;

   // Basic widths fixed by the field definitions.
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 17;
   localparam int LINE_W    = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 64;
   localparam int DLEN_W    = 4;

   // The delimiter register always holds this many byte slots.
   localparam int DELIM_SLOTS = CSR_DAT_W / BYTE_W;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [LINE_W-1:0]    line_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [DLEN_W-1:0]    dlen_type;

   // Configuration register indexes.
   localparam csr_idx_type CSR_DELIM_BYTES  = 4'd0;
   localparam csr_idx_type CSR_DELIM_LENGTH = 4'd1;
   localparam csr_idx_type CSR_MAX_PAYLOAD  = 4'd2;
   localparam csr_idx_type CSR_INCLUDE_DELIM = 4'd3;

   // Request operation codes.
   localparam logic OP_DATA    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Response status codes.
   localparam logic STATUS_LINE_READY  = 1'b0;
   localparam logic STATUS_LIMIT_ERROR = 1'b1;

   // Register reset values: a single newline delimiter and an 8 KiB limit.
   localparam logic [CSR_DAT_W-1:0] RESET_DELIM_BYTES = 64'd10;
   localparam dlen_type             RESET_DELIM_LENGTH = 4'd1;
   localparam line_type             RESET_MAX_PAYLOAD  = 16'd8192;
   localparam logic                 RESET_INCLUDE_DELIM = 1'b0;

   // The line counter saturates here.
   localparam count_type COUNT_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ----- sv/dlf_cell.sv -----
// One cell of the recent-byte row: holds one stream byte, hands it to the
// next cell on every shift and compares its incoming byte with the delimiter.
// Depends on dlf_pkg.
`default_nettype none

module dlf_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             shift_en,
   input  wire dlf_pkg::byte_type prev_byte,
   input  wire dlf_pkg::byte_type want_byte,
   input  wire logic             active,
   output dlf_pkg::byte_type     held_byte,
   output logic                  hit
);

   dlf_pkg::byte_type byte_ff;
   dlf_pkg::byte_type byte_in;

   // Take the neighbor's byte when the row shifts.
   assign byte_in = shift_en ? prev_byte : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // The compare looks at the byte this cell holds after the shift. A cell
   // beyond the delimiter length always agrees.
   assign hit       = !active || (prev_byte == want_byte);
   assign held_byte = byte_ff;

endmodule

`default_nettype wire

// ----- sv/delimiter_line_framer_unit.sv -----
// Top level of the delimiter line framer: configuration registers, the row
// of recent-byte cells, the line counter and the response register.
// Depends on dlf_pkg and dlf_cell.
`default_nettype none

// The framer takes one byte transaction per cycle and answers a completed
// line or a payload limit error in the cycle after the byte that causes it; a
// new request is taken in every cycle while the response register is empty
// or being drained. The delimiter search is a row of MAX_DELIM cells that
// shift the stream and compare in parallel, so the delimiter length does not
// delay the response. Request stall follows response stall only while a response
// waits in the output register. Configuration writes are always ready and
// must be made while no transaction is in flight.
module delimiter_line_framer_unit #(
   parameter int MAX_DELIM = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_op,
   input  wire logic [7:0]                     req_data_byte,
   // Response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_status,
   output logic [16:0]                         rsp_payload_size,
   output logic [16:0]                         rsp_frame_size,
   output logic [15:0]                         rsp_line_length,
   // Configuration write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire dlf_pkg::csr_idx_type           csr_index,
   input  wire logic [dlf_pkg::CSR_DAT_W-1:0]  csr_data
);

   localparam dlf_pkg::dlen_type MaxLen = dlf_pkg::DLEN_W'(MAX_DELIM);
   localparam int SlotIdxW = $clog2(dlf_pkg::DELIM_SLOTS);

   // Configuration registers.
   logic [dlf_pkg::CSR_DAT_W-1:0] delim_ff;
   dlf_pkg::dlen_type             dlen_ff;
   dlf_pkg::line_type             maxp_ff;
   logic                          incl_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= dlf_pkg::RESET_DELIM_BYTES;
         dlen_ff  <= dlf_pkg::RESET_DELIM_LENGTH;
         maxp_ff  <= dlf_pkg::RESET_MAX_PAYLOAD;
         incl_ff  <= dlf_pkg::RESET_INCLUDE_DELIM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dlf_pkg::CSR_DELIM_BYTES:   delim_ff <= csr_data;
            dlf_pkg::CSR_DELIM_LENGTH:  dlen_ff  <= csr_data[dlf_pkg::DLEN_W-1:0];
            dlf_pkg::CSR_MAX_PAYLOAD:   maxp_ff  <= csr_data[dlf_pkg::LINE_W-1:0];
            dlf_pkg::CSR_INCLUDE_DELIM: incl_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective delimiter length, clamped to the range of the cell row.
   dlf_pkg::dlen_type eff_len;

   always_comb begin
      if (dlen_ff == '0) begin
         eff_len = dlf_pkg::DLEN_W'(1);
      end else if (dlen_ff > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = dlen_ff;
      end
   end

   // Handshake.
   logic rsp_valid_ff;
   logic req_accept;
   logic shift_en;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign shift_en   = req_accept && (req_op == dlf_pkg::OP_DATA);

   // Delimiter bytes unpacked into slots; slot 0 is the first byte.
   dlf_pkg::byte_type delim_slot [dlf_pkg::DELIM_SLOTS];

   for (genvar s = 0; s < dlf_pkg::DELIM_SLOTS; s++) begin : g_slot
      assign delim_slot[s] = delim_ff[s*dlf_pkg::BYTE_W +: dlf_pkg::BYTE_W];
   end

   // Row of cells, newest byte in cell 0. Cell i meets delimiter byte
   // (length - 1 - i), so the last delimiter byte lines up with the newest.
   // The slot index is taken modulo the slot count, which still gives each
   // active cell its own slot.
   dlf_pkg::byte_type [MAX_DELIM-1:0] row_byte;
   logic              [MAX_DELIM-1:0] hit_vec;

   for (genvar g = 0; g < MAX_DELIM; g++) begin : g_cell
      logic [SlotIdxW-1:0] sel;
      dlf_pkg::byte_type   prev;
      logic                active;

      assign sel    = eff_len[SlotIdxW-1:0] - SlotIdxW'(1) - SlotIdxW'(g);
      assign active = dlf_pkg::DLEN_W'(g) < eff_len;

      if (g == 0) begin : g_head
         assign prev = req_data_byte;
      end else begin : g_body
         assign prev = row_byte[g-1];
      end

      dlf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .prev_byte (prev),
         .want_byte (delim_slot[sel]),
         .active    (active),
         .held_byte (row_byte[g]),
         .hit       (hit_vec[g])
      );
   end

   // Line counter and the framing decision for the current byte.
   dlf_pkg::count_type count_ff;
   dlf_pkg::count_type count_in;
   dlf_pkg::count_type count_inc;
   dlf_pkg::count_type len_ext;
   dlf_pkg::count_type maxp_ext;
   dlf_pkg::count_type line_full;
   dlf_pkg::count_type limit;
   logic               enough;
   logic               delim_hit;
   logic               line_over;
   logic               no_room;
   logic               produce;
   logic               is_error;

   assign count_inc = (count_ff == dlf_pkg::COUNT_MAX) ? count_ff
                                                        : count_ff + 17'd1;
   assign len_ext   = dlf_pkg::COUNT_W'(eff_len);
   assign maxp_ext  = dlf_pkg::COUNT_W'(maxp_ff);
   assign line_full = count_inc - len_ext;
   assign limit     = maxp_ext + len_ext - 17'd1;
   assign enough    = count_inc >= len_ext;
   assign delim_hit = enough && (&hit_vec);
   assign line_over = line_full > maxp_ext;
   assign no_room   = enough && (count_inc > limit);
   assign is_error  = delim_hit ? line_over : no_room;
   assign produce   = delim_hit || no_room;

   always_comb begin
      count_in = count_ff;
      if (req_accept) begin
         if (req_op == dlf_pkg::OP_RESTART || produce) begin
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register. It loads when empty or when its transaction leaves.
   logic               rsp_valid_in;
   logic               rsp_load;
   logic               status_ff;
   dlf_pkg::count_type payload_ff;
   dlf_pkg::count_type frame_ff;
   dlf_pkg::line_type  line_ff;

   assign rsp_load = shift_en && produce;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (is_error) begin
            status_ff  <= dlf_pkg::STATUS_LIMIT_ERROR;
            payload_ff <= '0;
            frame_ff   <= '0;
            line_ff    <= '0;
         end else begin
            status_ff  <= dlf_pkg::STATUS_LINE_READY;
            payload_ff <= incl_ff ? count_inc : line_full;
            frame_ff   <= count_inc;
            line_ff    <= line_full[dlf_pkg::LINE_W-1:0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_payload_size = payload_ff;
   assign rsp_frame_size   = frame_ff;
   assign rsp_line_length  = line_ff;

   // A completed line reports a frame that exceeds the line by the
   // delimiter length, and a payload that is one of the two.
   a_line_sizes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dlf_pkg::STATUS_LINE_READY) |->
         (rsp_frame_size == dlf_pkg::COUNT_W'(rsp_line_length) + len_ext) &&
         (rsp_payload_size == rsp_frame_size ||
          rsp_payload_size == dlf_pkg::COUNT_W'(rsp_line_length)))
      else $error("line response sizes are inconsistent");

   // An error response carries zero sizes.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dlf_pkg::STATUS_LIMIT_ERROR) |->
         (rsp_payload_size == '0 && rsp_frame_size == '0 && rsp_line_length == '0))
      else $error("error response has nonzero sizes");

   // Any response and any restart start a fresh line.
   a_line_restart : assert property (@(posedge clock) disable iff (reset)
      (rsp_load || (req_accept && req_op == dlf_pkg::OP_RESTART)) |=>
         (count_ff == '0))
      else $error("line counter not cleared after a response or restart");

   // A restart leaves the recent bytes untouched.
   a_restart_keeps_row : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == dlf_pkg::OP_RESTART) |=> $stable(row_byte))
      else $error("restart changed the recent-byte row");

   // A completed line never reports more than the payload limit allows.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !is_error) |-> (line_full <= maxp_ext))
      else $error("line response exceeds the payload limit");

endmodule

`default_nettype wire

// ----- verif/delimiter_line_framer_unit_tb.sv -----
// Self-checking testbench for delimiter_line_framer_unit: directed cases and
// randomized line streams under several pacing phases, checked against a
// built-in line framing predictor. Depends on dlf_pkg and the framer RTL.
`default_nettype none

module delimiter_line_framer_unit_tb;

   // A register index that maps to no register; writes to it change nothing.
   localparam dlf_pkg::csr_idx_type CSR_SPARE_INDEX = 4'd9;

   typedef struct packed {
      logic               status;
      dlf_pkg::count_type payload_size;
      dlf_pkg::count_type frame_size;
      dlf_pkg::line_type  line_length;
   } line_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_op = dlf_pkg::OP_DATA;
   dlf_pkg::byte_type             req_data_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_status;
   logic [16:0]                   rsp_payload_size;
   logic [16:0]                   rsp_frame_size;
   logic [15:0]                   rsp_line_length;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   dlf_pkg::csr_idx_type          csr_index = '0;
   logic [dlf_pkg::CSR_DAT_W-1:0] csr_data = '0;

   // Predictor state: recent bytes newest first, the line count and the
   // register copies.
   dlf_pkg::byte_type             hist_bytes [dlf_pkg::DELIM_SLOTS];
   dlf_pkg::count_type            line_count;
   logic [dlf_pkg::CSR_DAT_W-1:0] delim_cfg;
   dlf_pkg::dlen_type             dlen_cfg;
   dlf_pkg::line_type             max_cfg;
   logic                          incl_cfg;

   line_result_type expected_lines[$];
   line_result_type oldest_line;
   int              items_sent = 0;
   int              lines_seen = 0;
   int              limit_errors_seen = 0;
   int              fail_count = 0;
   int              idle_pct = 0;
   int              stall_pct = 0;

   delimiter_line_framer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_size (rsp_payload_size),
      .rsp_frame_size   (rsp_frame_size),
      .rsp_line_length  (rsp_line_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run ends here if the design stops making progress.
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Delimiter length as the block uses it: zero acts as one, and anything
   // above the slot count acts as the slot count.
   function automatic int active_delim_len();
      int n;
      n = int'(dlen_cfg);
      if (n == 0) n = 1;
      if (n > dlf_pkg::DELIM_SLOTS) n = dlf_pkg::DELIM_SLOTS;
      return n;
   endfunction

   function automatic void reset_framer_model();
      foreach (hist_bytes[i]) hist_bytes[i] = '0;
      line_count = '0;
      delim_cfg  = dlf_pkg::RESET_DELIM_BYTES;
      dlen_cfg   = dlf_pkg::RESET_DELIM_LENGTH;
      max_cfg    = dlf_pkg::RESET_MAX_PAYLOAD;
      incl_cfg   = dlf_pkg::RESET_INCLUDE_DELIM;
   endfunction

   // Advance the framing state by one accepted transaction and queue the
   // line or limit error that it produces, if any.
   function automatic void frame_next_item(input logic op, input dlf_pkg::byte_type data_in);
      int              n;
      int              cnt;
      int              line;
      bit              hit;
      line_result_type r;
      n = active_delim_len();
      if (op == dlf_pkg::OP_RESTART) begin
         line_count = '0;
         return;
      end
      for (int i = dlf_pkg::DELIM_SLOTS - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
      hist_bytes[0] = data_in;
      if (line_count != dlf_pkg::COUNT_MAX) line_count = line_count + 1'b1;
      cnt = int'(line_count);
      hit = (cnt >= n);
      for (int i = 0; i < n; i++) begin
         if (hist_bytes[n-1-i] != delim_cfg[8*i +: 8]) hit = 1'b0;
      end
      r = '0;
      if (hit) begin
         line = cnt - n;
         line_count = '0;
         if (line > int'(max_cfg)) begin
            r.status = dlf_pkg::STATUS_LIMIT_ERROR;
         end else begin
            r.status       = dlf_pkg::STATUS_LINE_READY;
            r.line_length  = dlf_pkg::LINE_W'(line);
            r.frame_size   = dlf_pkg::COUNT_W'(line + n);
            r.payload_size = incl_cfg ? dlf_pkg::COUNT_W'(line + n)
                                      : dlf_pkg::COUNT_W'(line);
         end
         expected_lines.push_back(r);
      end else if (cnt >= n && cnt - (n - 1) > int'(max_cfg)) begin
         line_count = '0;
         r.status = dlf_pkg::STATUS_LIMIT_ERROR;
         expected_lines.push_back(r);
      end
   endfunction

   task automatic report_field(input string name, input logic [16:0] exp_v,
                               input logic [16:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Every response transaction is compared with the oldest expected line.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            $display("%0t: unexpected response, expected none actual status %0d length %0d",
                     $time, rsp_status, rsp_line_length);
            fail_count++;
         end else begin
            oldest_line = expected_lines.pop_front();
            report_field("status", dlf_pkg::COUNT_W'(oldest_line.status),
                         dlf_pkg::COUNT_W'(rsp_status));
            report_field("payload_size", oldest_line.payload_size, rsp_payload_size);
            report_field("frame_size", oldest_line.frame_size, rsp_frame_size);
            report_field("line_length", dlf_pkg::COUNT_W'(oldest_line.line_length),
                         dlf_pkg::COUNT_W'(rsp_line_length));
            if (oldest_line.status == dlf_pkg::STATUS_LIMIT_ERROR) limit_errors_seen++;
            else lines_seen++;
         end
      end
   end

   // Send one request transaction, with random idle cycles ahead of it.
   task automatic push_stream_item(input logic op, input dlf_pkg::byte_type data_in);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data_in;
      do @(posedge clock); while (req_stall);
      frame_next_item(op, data_in);
      items_sent++;
   endtask

   // Lower the request valid and let every expected line drain, then wait out
   // a byte that is still in flight without a result.
   task automatic drain_lines();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_framer_reg(input dlf_pkg::csr_idx_type idx,
                                   input logic [dlf_pkg::CSR_DAT_W-1:0] value);
      drain_lines();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dlf_pkg::CSR_DELIM_BYTES:   delim_cfg = value;
         dlf_pkg::CSR_DELIM_LENGTH:  dlen_cfg  = value[dlf_pkg::DLEN_W-1:0];
         dlf_pkg::CSR_MAX_PAYLOAD:   max_cfg   = value[dlf_pkg::LINE_W-1:0];
         dlf_pkg::CSR_INCLUDE_DELIM: incl_cfg  = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_bytes(input dlf_pkg::byte_type b[]);
      foreach (b[i]) push_stream_item(dlf_pkg::OP_DATA, b[i]);
   endtask

   // Newline framing out of reset, byte extremes and a restart mid-line.
   task automatic test_newline_lines();
      send_bytes('{8'hFF, 8'h0A});
      push_stream_item(dlf_pkg::OP_DATA, 8'h00);
      push_stream_item(dlf_pkg::OP_RESTART, 8'hFF);
      push_stream_item(dlf_pkg::OP_DATA, 8'h0A);
   endtask

   // CR LF delimiter with the delimiter counted in the payload; a delimiter
   // split by a restart must not match.
   task automatic test_two_byte_delimiter();
      write_framer_reg(dlf_pkg::CSR_DELIM_BYTES, 64'h0A0D);
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, 64'd2);
      write_framer_reg(dlf_pkg::CSR_INCLUDE_DELIM, 64'd1);
      send_bytes('{8'h0D, 8'h0D, 8'h0A, 8'h0D});
      push_stream_item(dlf_pkg::OP_RESTART, 8'h00);
      send_bytes('{8'h0A, 8'h0D, 8'h0A});
   endtask

   // Length values above the slot count act as eight, and zero acts as one.
   task automatic test_length_clamp();
      write_framer_reg(dlf_pkg::CSR_DELIM_BYTES, 64'h0807_0605_0403_0201);
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, 64'd15);
      send_bytes('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, 64'd0);
      push_stream_item(dlf_pkg::OP_DATA, 8'h01);
   endtask

   // Limit errors: a zero limit, an early error once no delimiter can fit,
   // and a limit lowered while a line is open.
   task automatic test_payload_limit();
      write_framer_reg(dlf_pkg::CSR_DELIM_BYTES, 64'h0A);
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, 64'd1);
      write_framer_reg(dlf_pkg::CSR_MAX_PAYLOAD, 64'd0);
      write_framer_reg(dlf_pkg::CSR_INCLUDE_DELIM, 64'd0);
      write_framer_reg(CSR_SPARE_INDEX, 64'hFFFF_FFFF_FFFF_FFFF);
      send_bytes('{8'h0A, 8'h61});
      write_framer_reg(dlf_pkg::CSR_DELIM_BYTES, 64'h0A0D);
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, 64'd2);
      write_framer_reg(dlf_pkg::CSR_MAX_PAYLOAD, 64'd3);
      send_bytes('{8'h61, 8'h62, 8'h63, 8'h64, 8'h65});
      write_framer_reg(dlf_pkg::CSR_MAX_PAYLOAD, 64'd8);
      send_bytes('{8'h61, 8'h62, 8'h63, 8'h0D});
      write_framer_reg(dlf_pkg::CSR_MAX_PAYLOAD, 64'd1);
      push_stream_item(dlf_pkg::OP_DATA, 8'h0A);
   endtask

   // Byte for line content: often a delimiter byte, to provoke partial and
   // overlapping matches.
   function automatic dlf_pkg::byte_type line_content_byte();
      if ($urandom_range(0, 1) == 0) return delim_cfg[8*$urandom_range(0, active_delim_len()-1) +: 8];
      return dlf_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   // One pacing phase: new framing registers, then mostly complete lines
   // with random content, mixed with restarts, noise and cut delimiters.
   task automatic test_random_phase(input int count, input int sender_idle,
                                    input int receiver_stall, input int dlen_value,
                                    input int max_value, input bit hold_off);
      int stop_at;
      int len;
      int n;
      int pick;
      drain_lines();
      write_framer_reg(dlf_pkg::CSR_DELIM_BYTES, {$urandom, $urandom});
      write_framer_reg(dlf_pkg::CSR_DELIM_LENGTH, dlf_pkg::CSR_DAT_W'(dlen_value));
      write_framer_reg(dlf_pkg::CSR_MAX_PAYLOAD, dlf_pkg::CSR_DAT_W'(max_value));
      write_framer_reg(dlf_pkg::CSR_INCLUDE_DELIM,
                       dlf_pkg::CSR_DAT_W'($urandom_range(0, 1)));
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      stop_at   = items_sent + count;
      while (items_sent < stop_at) begin
         if (hold_off && items_sent >= stop_at - count / 2) begin
            drain_lines();
            hold_off = 1'b0;
         end
         pick = int'($urandom_range(0, 99));
         n = active_delim_len();
         if (pick < 5) begin
            push_stream_item(dlf_pkg::OP_RESTART, dlf_pkg::BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 10) begin
            push_stream_item(dlf_pkg::OP_DATA, dlf_pkg::BYTE_W'($urandom_range(0, 255)));
         end else begin
            len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 30))
                                              : int'($urandom_range(0, 12));
            repeat (len) push_stream_item(dlf_pkg::OP_DATA, line_content_byte());
            // Now and then the delimiter is cut short.
            if ($urandom_range(0, 9) == 0) n = int'($urandom_range(0, n - 1));
            for (int i = 0; i < n; i++) push_stream_item(dlf_pkg::OP_DATA, delim_cfg[8*i +: 8]);
         end
      end
      drain_lines();
   endtask

   initial begin
      reset_framer_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_newline_lines();
      test_two_byte_delimiter();
      test_length_clamp();
      test_payload_limit();
      test_random_phase(320, 0, 0, 8, 65535, 1'b0);
      test_random_phase(320, 49, 0, int'($urandom_range(2, 7)),
                        int'($urandom_range(4, 20)), 1'b1);
      test_random_phase(320, 0, 49, 1, 3, 1'b0);
      test_random_phase(320, 6, 6, 15, int'($urandom_range(0, 65535)), 1'b0);

      // Wait out the last lines, with a bound, then let the bench settle.
      @(negedge clock);
      req_valid <= 1'b0;
      for (int i = 0; i < 2000 && expected_lines.size() != 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_lines.size() != 0) begin
         $display("%0t: %0d expected lines never arrived", $time, expected_lines.size());
         fail_count++;
      end

      $display("Sent %0d stream transactions over four pacing phases.", items_sent);
      $display("Checked %0d framed lines and %0d payload limit errors.",
               lines_seen, limit_errors_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
